### design/rfc_pkg.sv
`default_nettype none
package rfc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned NAK_LEN = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;
	localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h28;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h0D;

	// "(NAKss"
	localparam logic [BYTE_W-1:0] NAK_TEXT [NAK_LEN] = '{8'h28, 8'h4E, 8'h41, 8'h4B, 8'h73, 8'h73};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_END_BYTE   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_end;
		logic              crc_ok;
		logic              nak_seen;
		logic [CRC_W-1:0]  calc_crc;
		logic [CRC_W-1:0]  recv_crc;
		logic [BYTE_W-1:0] frame_length;
	} result_t;

	// CRC-16/XMODEM, one byte, MSB first
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != '0) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### design/response_frame_checker_unit.sv
// channel | valid    | stall     | payload
// rx      | rx_valid | rx_stall  | rx_byte
// res     | res_valid| res_stall | frame_byte frame_end crc_ok nak_seen calc_crc recv_crc
//         |          |           | frame_length
// cfg     | cfg_we   | -         | cfg_index cfg_data
// One byte per cycle while the result is not stalled; rx accept to res_valid passes the
// input register, then frame logic with a one-byte CRC step into the result register.
// Bytes outside a frame are consumed without a result.
// Reset clears the frame state and loads '(' and CR as start and end bytes.
// A stalled result holds; rx_stall rises only when a byte waits behind it.
`default_nettype none
module response_frame_checker_unit #(
	parameter int unsigned MAX_FRAME_LEN = 255
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          rx_valid,
	output logic                         rx_stall,
	input  wire [rfc_pkg::BYTE_W-1:0]    rx_byte,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic [rfc_pkg::BYTE_W-1:0]   frame_byte,
	output logic                         frame_end,
	output logic                         crc_ok,
	output logic                         nak_seen,
	output logic [rfc_pkg::CRC_W-1:0]    calc_crc,
	output logic [rfc_pkg::CRC_W-1:0]    recv_crc,
	output logic [rfc_pkg::BYTE_W-1:0]   frame_length,
	input  wire                          cfg_we,
	input  wire [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [rfc_pkg::BYTE_W-1:0]    cfg_data
);
	import rfc_pkg::*;

	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] end_byte_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	logic              emit;
	result_t           result;
	logic              res_valid_q;
	result_t           res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_START_BYTE) begin
				start_byte_q <= cfg_data;
			end else if (cfg_index == REG_END_BYTE) begin
				end_byte_q <= cfg_data;
			end
		end
	end

	assign out_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && out_free;
	assign rx_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	rfc_core #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.start_byte(start_byte_q),
		.end_byte  (end_byte_q),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= result;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_byte   = res_q.frame_byte;
	assign frame_end    = res_q.frame_end;
	assign crc_ok       = res_q.crc_ok;
	assign nak_seen     = res_q.nak_seen;
	assign calc_crc     = res_q.calc_crc;
	assign recv_crc     = res_q.recv_crc;
	assign frame_length = res_q.frame_length;

endmodule
`default_nettype wire

### design/rfc_core.sv
`default_nettype none
module rfc_core #(
	parameter int unsigned MAX_FRAME_LEN = 255
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire [rfc_pkg::BYTE_W-1:0] rx_byte,
	input  wire [rfc_pkg::BYTE_W-1:0] start_byte,
	input  wire [rfc_pkg::BYTE_W-1:0] end_byte,
	output logic                     emit,
	output rfc_pkg::result_t         result
);
	import rfc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);

	logic              in_frame_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] held_q [2];
	logic [BYTE_W-1:0] recent_q [5];
	logic              nak_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              starting;
	logic              is_end;
	logic [CRC_W-1:0]  crc_e;
	logic [BYTE_W-1:0] held_e [2];
	logic [BYTE_W-1:0] recent_e [5];
	logic              nak_e;
	logic [CNT_W-1:0]  cnt_e;
	logic              match;
	logic              nak_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [CNT_W+7:0]  cnt_ext;
	logic              crc_live;
	logic [CRC_W-1:0]  recv;

	always_comb begin
		starting = !in_frame_q && (rx_byte == start_byte);
		emit     = in_frame_q || starting;
		is_end   = in_frame_q && (rx_byte != start_byte) && (rx_byte == end_byte);

		// a new frame sees cleared state
		crc_e = starting ? CRC_INIT : crc_q;
		nak_e = starting ? 1'b0 : nak_q;
		cnt_e = starting ? '0 : cnt_q;
		for (int i = 0; i < 2; i++) begin
			held_e[i] = starting ? '0 : held_q[i];
		end
		for (int i = 0; i < 5; i++) begin
			recent_e[i] = starting ? '0 : recent_q[i];
		end

		match = (rx_byte == NAK_TEXT[5]);
		for (int i = 0; i < 5; i++) begin
			if (recent_e[i] != NAK_TEXT[i]) begin
				match = 1'b0;
			end
		end
		nak_new = nak_e || match;

		cnt_new  = (cnt_e < CNT_W'(MAX_FRAME_LEN)) ? cnt_e + CNT_W'(1) : cnt_e;
		cnt_ext  = {8'h00, cnt_new};
		crc_live = (cnt_e >= CNT_W'(2));
		recv     = {held_e[0], held_e[1]};

		result              = '0;
		result.frame_byte   = rx_byte;
		result.frame_end    = is_end;
		if (is_end) begin
			result.nak_seen     = nak_new;
			result.frame_length = cnt_ext[7:0];
			if (crc_live) begin
				result.crc_ok   = (recv == crc_e);
				result.calc_crc = crc_e;
				result.recv_crc = recv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q      <= CRC_INIT;
			nak_q      <= 1'b0;
			cnt_q      <= '0;
			for (int i = 0; i < 2; i++) begin
				held_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				recent_q[i] <= '0;
			end
		end else if (en && emit) begin
			if (is_end) begin
				in_frame_q <= 1'b0;
				crc_q      <= CRC_INIT;
				nak_q      <= 1'b0;
				cnt_q      <= '0;
				for (int i = 0; i < 2; i++) begin
					held_q[i] <= '0;
				end
				for (int i = 0; i < 5; i++) begin
					recent_q[i] <= '0;
				end
			end else begin
				in_frame_q <= 1'b1;
				crc_q      <= crc_live ? crc_feed(crc_e, held_e[0]) : crc_e;
				nak_q      <= nak_new;
				cnt_q      <= cnt_new;
				held_q[0]  <= held_e[1];
				held_q[1]  <= rx_byte;
				for (int i = 0; i < 4; i++) begin
					recent_q[i] <= recent_e[i+1];
				end
				recent_q[4] <= rx_byte;
			end
		end
	end

endmodule
`default_nettype wire

### design/rfc_checker.sv
`default_nettype none
module rfc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          res_valid,
	input wire                          res_stall,
	input wire [rfc_pkg::BYTE_W-1:0]    frame_byte,
	input wire                          frame_end,
	input wire                          crc_ok,
	input wire                          nak_seen,
	input wire [rfc_pkg::CRC_W-1:0]     calc_crc,
	input wire [rfc_pkg::CRC_W-1:0]     recv_crc,
	input wire [rfc_pkg::BYTE_W-1:0]    frame_length
);
	import rfc_pkg::*;

	// held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(frame_byte) && $stable(frame_end)
			&& $stable(calc_crc) && $stable(recv_crc) && $stable(frame_length))
		else $error("result changed while stalled");

	// summary fields only on the closing byte
	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_end |-> !crc_ok && !nak_seen && calc_crc == '0
			&& recv_crc == '0 && frame_length == '0)
		else $error("summary fields set on a mid-frame item");

	a_crc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && crc_ok |-> frame_end && calc_crc == recv_crc)
		else $error("crc_ok inconsistent with reported CRCs");

	a_crc_bad: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end && !crc_ok |-> calc_crc != recv_crc || recv_crc == '0)
		else $error("crc_ok low with matching nonzero CRCs");

endmodule

bind response_frame_checker_unit rfc_checker u_rfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.frame_byte  (frame_byte),
	.frame_end   (frame_end),
	.crc_ok      (crc_ok),
	.nak_seen    (nak_seen),
	.calc_crc    (calc_crc),
	.recv_crc    (recv_crc),
	.frame_length(frame_length)
);
`default_nettype wire

### sim/response_frame_checker_unit_test.sv
`timescale 1ns / 1ps
module response_frame_checker_unit_test;
	import rfc_pkg::*;

	localparam int unsigned FRAME_LEN_MAX = 255;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 35;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_valid = 1'b0;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 res_stall = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	logic                 rx_stall;
	logic                 res_valid;
	logic [BYTE_W-1:0]    frame_byte;
	logic                 frame_end;
	logic                 crc_ok;
	logic                 nak_seen;
	logic [CRC_W-1:0]     calc_crc;
	logic [CRC_W-1:0]     recv_crc;
	logic [BYTE_W-1:0]    frame_length;

	// framer state as the testbench sees it
	logic [BYTE_W-1:0] start_val;
	logic [BYTE_W-1:0] end_val;
	logic              framing;
	logic [CRC_W-1:0]  crc_acc;
	logic [BYTE_W-1:0] crc_hold [2];
	logic [BYTE_W-1:0] nak_window [5];
	logic              nak_hit;
	int unsigned       len_count;

	result_t           due_results [$];
	logic [BYTE_W-1:0] body_bytes [$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned bytes_checked = 0;
	int unsigned frames_closed = 0;
	int unsigned nak_frames = 0;
	int unsigned crc_good_frames = 0;
	int unsigned results_predicted = 0;
	int unsigned settings_used = 1;
	int unsigned cycle_count = 0;

	response_frame_checker_unit #(
		.MAX_FRAME_LEN(FRAME_LEN_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.crc_ok(crc_ok),
		.nak_seen(nak_seen),
		.calc_crc(calc_crc),
		.recv_crc(recv_crc),
		.frame_length(frame_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// bitwise XMODEM step, data MSB first
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ d[i];
			c = {c[CRC_W-2:0], 1'b0};
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic void clear_frame_state();
		crc_acc = CRC_INIT;
		crc_hold = '{default: '0};
		nak_window = '{default: '0};
		nak_hit = 1'b0;
		len_count = 0;
	endfunction

	task automatic predict_rx_byte(input logic [BYTE_W-1:0] b);
		result_t     r;
		logic        closing;
		logic        hit;
		int unsigned prior;
		closing = 1'b0;
		if (!framing) begin
			if (b != start_val) return;
			framing = 1'b1;
			clear_frame_state();
		end else if (b != start_val && b == end_val) begin
			closing = 1'b1;
		end
		hit = (b == NAK_TEXT[NAK_LEN-1]);
		for (int k = 0; k < NAK_LEN - 1; k++)
			if (nak_window[k] != NAK_TEXT[k]) hit = 1'b0;
		if (hit) nak_hit = 1'b1;
		for (int k = 0; k < 4; k++) nak_window[k] = nak_window[k+1];
		nak_window[4] = b;
		prior = len_count;
		if (len_count < FRAME_LEN_MAX) len_count++;
		r = '0;
		r.frame_byte = b;
		if (!closing) begin
			if (prior >= 2) crc_acc = crc16_byte(crc_acc, crc_hold[0]);
			crc_hold[0] = crc_hold[1];
			crc_hold[1] = b;
		end else begin
			r.frame_end = 1'b1;
			r.nak_seen = nak_hit;
			r.frame_length = BYTE_W'(len_count);
			if (prior >= 2) begin
				r.recv_crc = {crc_hold[0], crc_hold[1]};
				r.calc_crc = crc_acc;
				r.crc_ok = (r.recv_crc == crc_acc);
			end
			framing = 1'b0;
			clear_frame_state();
		end
		due_results.push_back(r);
		results_predicted++;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
			want);
	endtask

	task automatic check_frame_result();
		result_t want;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected item, frame_byte", frame_byte, 0);
			return;
		end
		want = due_results.pop_front();
		bytes_checked++;
		if (frame_byte !== want.frame_byte)
			report_mismatch("frame_byte", frame_byte, want.frame_byte);
		if (frame_end !== want.frame_end)
			report_mismatch("frame_end", frame_end, want.frame_end);
		if (crc_ok !== want.crc_ok)
			report_mismatch("crc_ok", crc_ok, want.crc_ok);
		if (nak_seen !== want.nak_seen)
			report_mismatch("nak_seen", nak_seen, want.nak_seen);
		if (calc_crc !== want.calc_crc)
			report_mismatch("calc_crc", calc_crc, want.calc_crc);
		if (recv_crc !== want.recv_crc)
			report_mismatch("recv_crc", recv_crc, want.recv_crc);
		if (frame_length !== want.frame_length)
			report_mismatch("frame_length", frame_length, want.frame_length);
		if (want.frame_end) begin
			frames_closed++;
			nak_frames += want.nak_seen;
			crc_good_frames += want.crc_ok;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) check_frame_result();
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		predict_rx_byte(b);
	endtask

	task automatic wait_drained(input bit settle);
		rx_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_BYTE: start_val = val;
			REG_END_BYTE: end_val = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_framing(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
		wait_drained(1);
		write_reg(REG_START_BYTE, s);
		write_reg(REG_END_BYTE, e);
		settings_used++;
	endtask

	// random body without the end byte, optionally carrying the NAK text
	task automatic fill_body(input int unsigned len, input bit with_nak);
		logic [BYTE_W-1:0] x;
		int unsigned       pos;
		body_bytes.delete();
		repeat (len) begin
			do x = BYTE_W'($urandom_range(255)); while (x == end_val);
			body_bytes.push_back(x);
		end
		if (with_nak && len >= NAK_LEN) begin
			pos = $urandom_range(len - NAK_LEN);
			for (int k = 0; k < NAK_LEN; k++) body_bytes[pos+k] = NAK_TEXT[k];
		end
	endtask

	task automatic send_frame(input bit crc_good, input bit closed);
		logic [CRC_W-1:0] c;
		c = crc16_byte(CRC_INIT, start_val);
		foreach (body_bytes[i]) c = crc16_byte(c, body_bytes[i]);
		if (!crc_good) c = c ^ CRC_W'($urandom_range(65535, 1));
		send_byte(start_val);
		foreach (body_bytes[i]) send_byte(body_bytes[i]);
		send_byte(c[15:8]);
		send_byte(c[7:0]);
		if (closed) send_byte(end_val);
	endtask

	task automatic test_directed();
		// end byte and noise while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(END_BYTE_RST);
		// two- and three-byte frames
		send_byte(START_BYTE_RST);
		send_byte(END_BYTE_RST);
		send_byte(START_BYTE_RST);
		send_byte(8'h5A);
		send_byte(END_BYTE_RST);
		body_bytes = '{NAK_TEXT[1], NAK_TEXT[2], NAK_TEXT[3], NAK_TEXT[4], NAK_TEXT[5]};
		send_frame(1'b1, 1'b1);
		// start byte inside a frame is plain data
		body_bytes = '{START_BYTE_RST, 8'h00, 8'hFF};
		send_frame(1'b0, 1'b1);
		wait_drained(0);
	endtask

	task automatic test_config();
		set_framing(8'h00, 8'hFF);
		write_reg(REG_SPARE_A, BYTE_W'($urandom_range(255)));
		write_reg(REG_SPARE_B, BYTE_W'($urandom_range(255)));
		send_byte(8'hFF);
		// three-byte frame whose received CRC is zero
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		fill_body(4, 1'b0);
		send_frame(1'b1, 1'b1);
		set_framing(8'hFF, 8'h00);
		fill_body(8, 1'b1);
		send_frame(1'b1, 1'b1);
		send_byte(8'h00);
		// NAK window must not carry over from the previous frame
		set_framing(NAK_TEXT[5], NAK_TEXT[3]);
		send_byte(NAK_TEXT[5]);
		for (int k = 0; k < 4; k++) send_byte(NAK_TEXT[k]);
		send_byte(NAK_TEXT[5]);
		send_byte(NAK_TEXT[5]);
		send_byte(NAK_TEXT[3]);
		// equal start and end: the frame stays open until end changes
		set_framing(8'h55, 8'h55);
		send_byte(8'h55);
		send_byte(8'h12);
		send_byte(8'h55);
		send_byte(8'h34);
		wait_drained(1);
		write_reg(REG_END_BYTE, 8'hAA);
		send_byte(8'hAA);
		set_framing(START_BYTE_RST, END_BYTE_RST);
		wait_drained(0);
	endtask

	task automatic test_long_frames();
		// one byte past the length limit
		fill_body(FRAME_LEN_MAX - 3, 1'b1);
		send_frame(1'b1, 1'b1);
		wait_drained(0);
	endtask

	task automatic test_random();
		int unsigned       goal;
		int unsigned       kind;
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] e;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 67; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 67; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			if (phase % 2 == 1) begin
				s = BYTE_W'($urandom_range(255));
				do e = BYTE_W'($urandom_range(255)); while (e == s);
				set_framing(s, e);
			end else if (phase == 2) begin
				set_framing(START_BYTE_RST, END_BYTE_RST);
			end
			goal = results_predicted + ITEMS_PER_PHASE;
			while (results_predicted < goal) begin
				kind = $urandom_range(99);
				if (kind < 55) begin
					fill_body($urandom_range(12), 1'b0);
					send_frame(1'b1, 1'b1);
				end else if (kind < 67) begin
					fill_body($urandom_range(12), 1'b0);
					send_frame(1'b0, 1'b1);
				end else if (kind < 77) begin
					fill_body($urandom_range(14, 6), 1'b1);
					send_frame($urandom_range(1), 1'b1);
				end else if (kind < 83) begin
					fill_body($urandom_range(8), 1'b0);
					send_frame(1'b1, 1'b0);
				end else if (kind < 91) begin
					send_byte(start_val);
					if ($urandom_range(1)) send_byte(BYTE_W'($urandom_range(255)));
					send_byte(end_val);
				end else begin
					repeat ($urandom_range(4, 1))
						send_byte($urandom_range(1) ? end_val : BYTE_W'($urandom_range(255)));
				end
				if ($urandom_range(29) == 0) wait_drained(0);
			end
		end
		idle_pct = 0;
		stall_pct = 0;
		wait_drained(0);
	endtask

	initial begin
		start_val = START_BYTE_RST;
		end_val = END_BYTE_RST;
		framing = 1'b0;
		clear_frame_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config();
		test_long_frames();
		test_random();
		wait_drained(1);
		$display("summary: %0d frame bytes checked, %0d frames closed over %0d delimiter settings",
			bytes_checked, frames_closed, settings_used);
		$display("summary: %0d frames with good CRC, %0d with NAK text, %0d mismatches",
			crc_good_frames, nak_frames, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
